// ===== src/assert_macros.svh =====
// Assertion macros shared by the canvas rasterizer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, muted while rst_n is low
`define CCSR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge
`define CCSR_ASSERT_NEVER(name, expr, msg) \
    `CCSR_ASSERT(name, !(expr), msg)

`endif

// ===== src/ccsr_pkg.sv =====
// Shared types and constants of the character canvas rasterizer
`timescale 1ns / 1ps

package ccsr_pkg;

    // Address bits for the largest canvas (127 x 127 cells)
    localparam int CCSR_AW = 14;
    // Signed coordinate width, wide enough for shape corners and triangle edges
    localparam int CCSR_SW = 10;
    // Row and column index width
    localparam int CCSR_RW = 7;

    localparam logic [7:0] BACKGROUND_CODE = 8'd95;

    localparam logic [2:0] KIND_RECT  = 3'd0;
    localparam logic [2:0] KIND_LINE  = 3'd1;
    localparam logic [2:0] KIND_TRI   = 3'd2;
    localparam logic [2:0] KIND_CLEAR = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    typedef logic signed [CCSR_SW-1:0] coord_t;

    // Command as classified by the front end
    typedef struct packed {
        logic [2:0]         kind;
        logic               skip;        // nothing to draw, or read off canvas
        logic               first_span;  // first clipped row is a full span
        logic               last_span;   // last clipped row is a full span
        logic               slope;       // edges widen by one column per row
        logic [CCSR_RW-1:0] row_first;
        logic [CCSR_RW-1:0] row_last;
        coord_t             left;        // edge columns on the first row
        coord_t             right;
        logic [CCSR_AW-1:0] addr;        // first row base, or read cell address
        logic [7:0]         ink;
    } ccsr_cmd_t;

    typedef struct packed {
        logic init_busy;
    } ccsr_status_t;

endpackage

// ===== src/ccsr_ram.sv =====
// Generic single-port RAM with registered read
`timescale 1ns / 1ps

module ccsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1500,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ccsr_front.sv =====
// Front end: accept a command beat, clip it and turn it into a draw command
`timescale 1ns / 1ps

module ccsr_front
    import ccsr_pkg::*;
#(
    parameter int ROWS = 25,
    parameter int COLS = 60
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       hold,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] in_kind,
    input  logic [7:0] in_row,
    input  logic [7:0] in_col,
    input  logic [7:0] in_end_col,
    input  logic [6:0] in_height,
    input  logic [6:0] in_width,
    input  logic [7:0] in_ink,
    input  logic       q_full,
    output logic       q_push,
    output ccsr_cmd_t  q_cmd
);

    localparam coord_t ROWS_MAX = coord_t'(ROWS - 1);
    localparam coord_t COLS_MAX = coord_t'(COLS - 1);
    localparam coord_t ZERO     = coord_t'(0);
    localparam coord_t ONE      = coord_t'(1);

    logic       s1_valid_reg, s1_valid_next;
    logic [2:0] kind_reg;
    logic [7:0] row_reg, col_reg, end_col_reg, ink_reg;
    logic [6:0] height_reg, width_reg;
    logic       accept;

    coord_t r, c, ce, h, w;
    coord_t bot, left, right, rs, re, offs;
    logic   zero, is_tri, shape, on_canvas;
    logic [CCSR_RW-1:0] mrow, mcol;

    assign q_push   = s1_valid_reg && !q_full;
    assign in_ready = !hold && (!s1_valid_reg || !q_full);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (q_push)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= in_kind;
            row_reg     <= in_row;
            col_reg     <= in_col;
            end_col_reg <= in_end_col;
            height_reg  <= in_height;
            width_reg   <= in_width;
            ink_reg     <= in_ink;
        end
    end

    // Shape bounds, clipped rows and first-row edges
    always_comb
    begin
        r  = $signed({{(CCSR_SW-8){row_reg[7]}}, row_reg});
        c  = $signed({{(CCSR_SW-8){col_reg[7]}}, col_reg});
        ce = $signed({{(CCSR_SW-8){end_col_reg[7]}}, end_col_reg});
        h  = $signed({{(CCSR_SW-7){1'b0}}, height_reg});
        w  = $signed({{(CCSR_SW-7){1'b0}}, width_reg});

        bot    = r;
        left   = c;
        right  = c;
        zero   = 1'b0;
        is_tri = 1'b0;
        shape  = 1'b1;
        unique case (kind_reg)
            KIND_RECT:
            begin
                bot   = r + h - ONE;
                right = c + w - ONE;
                zero  = (height_reg == 7'd0) || (width_reg == 7'd0);
            end
            KIND_LINE:
            begin
                right = ce;
            end
            KIND_TRI:
            begin
                bot    = r + h - ONE;
                zero   = (height_reg == 7'd0);
                is_tri = 1'b1;
            end
            default:
            begin
                shape = 1'b0;
            end
        endcase

        rs   = (r < ZERO) ? ZERO : r;
        re   = (bot > ROWS_MAX) ? ROWS_MAX : bot;
        offs = rs - r;

        on_canvas = (r >= ZERO) && (r <= ROWS_MAX) && (c >= ZERO) && (c <= COLS_MAX);

        mrow = (kind_reg == KIND_READ) ? r[CCSR_RW-1:0] : rs[CCSR_RW-1:0];
        mcol = (kind_reg == KIND_READ) ? c[CCSR_RW-1:0] : '0;

        q_cmd.kind       = kind_reg;
        q_cmd.skip       = shape ? (zero || (rs > re))
                                 : ((kind_reg == KIND_READ) && !on_canvas);
        q_cmd.first_span = (kind_reg == KIND_RECT) && (r >= ZERO);
        q_cmd.last_span  = (bot <= ROWS_MAX);
        q_cmd.slope      = is_tri;
        q_cmd.row_first  = rs[CCSR_RW-1:0];
        q_cmd.row_last   = re[CCSR_RW-1:0];
        q_cmd.left       = is_tri ? (c - offs) : left;
        q_cmd.right      = is_tri ? (c + offs) : right;
        q_cmd.addr       = CCSR_AW'(mrow) * CCSR_AW'(COLS) + CCSR_AW'(mcol);
        q_cmd.ink        = ink_reg;
    end

endmodule

// ===== src/ccsr_fifo.sv =====
// Short command queue between the front end and the draw engine
`timescale 1ns / 1ps

module ccsr_fifo
    import ccsr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ccsr_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output ccsr_cmd_t pop_cmd,
    output logic      empty
);

    ccsr_cmd_t       slots [QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]    count_reg;

    assign full    = (count_reg == (QAW+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = slots[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== src/ccsr_back.sv =====
// Draw engine: walk clipped rows and cells, sweep clears, read cells, post results
`timescale 1ns / 1ps

module ccsr_back
    import ccsr_pkg::*;
#(
    parameter int ROWS = 25,
    parameter int COLS = 60,
    localparam int DEPTH = ROWS * COLS,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_empty,
    output logic         q_pop,
    input  ccsr_cmd_t    q_cmd,
    output logic         ram_en,
    output logic         ram_we,
    output logic [AW-1:0] ram_addr,
    output logic [7:0]   ram_wdata,
    input  logic [7:0]   ram_rdata,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [2:0]   out_kind,
    output logic [7:0]   out_value,
    output ccsr_status_t status
);

    localparam coord_t COLS_MAX = coord_t'(COLS - 1);
    localparam coord_t ZERO     = coord_t'(0);
    localparam coord_t ONE      = coord_t'(1);
    localparam logic [CCSR_AW-1:0] LAST_CELL = CCSR_AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_ROW,
        ST_SPAN,
        ST_PT_L,
        ST_PT_R,
        ST_CLEAR,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    ccsr_cmd_t          cmd_reg, cmd_next;
    logic [CCSR_RW-1:0] row_reg, row_next;
    logic [CCSR_RW-1:0] col_reg, col_next;
    logic [CCSR_RW-1:0] end_reg, end_next;
    logic [CCSR_AW-1:0] base_reg, base_next;
    logic [CCSR_AW-1:0] cnt_reg, cnt_next;
    coord_t             left_reg, left_next;
    coord_t             right_reg, right_next;
    logic [7:0]         value_reg, value_next;
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_kind_reg, out_kind_next;
    logic [7:0]         out_value_reg, out_value_next;

    logic [CCSR_AW-1:0] addr_w;
    logic               last_row, is_span, left_on, right_on, step_row;
    coord_t             lo_s, hi_s;

    assign last_row = (row_reg == cmd_reg.row_last);
    assign is_span  = ((row_reg == cmd_reg.row_first) && cmd_reg.first_span)
                   || (last_row && cmd_reg.last_span);
    assign lo_s     = (left_reg < ZERO) ? ZERO : left_reg;
    assign hi_s     = (right_reg > COLS_MAX) ? COLS_MAX : right_reg;
    assign left_on  = (left_reg >= ZERO) && (left_reg <= COLS_MAX);
    assign right_on = (right_reg >= ZERO) && (right_reg <= COLS_MAX);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        end_next       = end_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        q_pop          = 1'b0;
        ram_en         = 1'b0;
        ram_we         = 1'b0;
        addr_w         = '0;
        ram_wdata      = cmd_reg.ink;
        step_row       = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                addr_w    = cnt_reg;
                ram_wdata = BACKGROUND_CODE;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    value_next = 8'd0;
                    row_next   = q_cmd.row_first;
                    base_next  = q_cmd.addr;
                    left_next  = q_cmd.left;
                    right_next = q_cmd.right;
                    cnt_next   = '0;
                    unique case (q_cmd.kind)
                        KIND_CLEAR:                   state_next = ST_CLEAR;
                        KIND_READ:
                            state_next = q_cmd.skip ? ST_DONE : ST_RD_ISSUE;
                        KIND_RECT, KIND_LINE, KIND_TRI:
                            state_next = q_cmd.skip ? ST_DONE : ST_ROW;
                        default:                      state_next = ST_DONE;
                    endcase
                end
            end
            ST_ROW:
            begin
                if (is_span)
                begin
                    col_next = lo_s[CCSR_RW-1:0];
                    end_next = hi_s[CCSR_RW-1:0];
                    if (lo_s > hi_s)
                        step_row = 1'b1;
                    else
                        state_next = ST_SPAN;
                end
                else
                begin
                    state_next = ST_PT_L;
                end
            end
            ST_SPAN:
            begin
                ram_en = 1'b1;
                ram_we = 1'b1;
                addr_w = base_reg + CCSR_AW'(col_reg);
                if (col_reg == end_reg)
                    step_row = 1'b1;
                else
                    col_next = col_reg + 1'b1;
            end
            ST_PT_L:
            begin
                ram_en     = left_on;
                ram_we     = left_on;
                addr_w     = base_reg + CCSR_AW'(left_reg[CCSR_RW-1:0]);
                state_next = ST_PT_R;
            end
            ST_PT_R:
            begin
                ram_en   = right_on;
                ram_we   = right_on;
                addr_w   = base_reg + CCSR_AW'(right_reg[CCSR_RW-1:0]);
                step_row = 1'b1;
            end
            ST_RD_ISSUE:
            begin
                ram_en     = 1'b1;
                addr_w     = cmd_reg.addr;
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                value_next = ram_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = cmd_reg.kind;
                    out_value_next = value_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance to the next clipped row, or finish after the last one
        if (step_row)
        begin
            if (last_row)
            begin
                state_next = ST_DONE;
            end
            else
            begin
                row_next   = row_reg + 1'b1;
                base_next  = base_reg + CCSR_AW'(COLS);
                state_next = ST_ROW;
                if (cmd_reg.slope)
                begin
                    left_next  = left_reg - ONE;
                    right_next = right_reg + ONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cmd_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            end_reg       <= '0;
            base_reg      <= '0;
            cnt_reg       <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            value_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= '0;
            out_value_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            end_reg       <= end_next;
            base_reg      <= base_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            value_reg     <= value_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_value_reg <= out_value_next;
        end
    end

    assign ram_addr         = addr_w[AW-1:0];
    assign out_valid        = out_valid_reg;
    assign out_kind         = out_kind_reg;
    assign out_value        = out_value_reg;
    assign status.init_busy = (state_reg == ST_INIT);

endmodule

// ===== src/char_canvas_shape_rasterizer.sv =====
// Top level of the character canvas shape rasterizer
//
//  Channel  | Direction | Handshake                     | Payload
//  ---------+-----------+-------------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata: draw fields, tuser: kind
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata: cell value, tuser: kind
//
//  The single-port canvas RAM takes one cell a cycle, so a command draws cell by cell. A read
//  issues the cell address and registers the returned value; a shape walks its clipped
//  rows, a full span cell by cell and any other row as a left and a right point; a
//  clear sweeps every cell; a clipped-away shape goes straight to its result.
//  After reset the canvas is swept to underscore with s_axis_tready low.
//  The front register and a two-entry queue take new beats while the engine draws;
//  the result register holds a beat under m_axis_tready low; input stalls once both are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module char_canvas_shape_rasterizer
    import ccsr_pkg::*;
#(
    parameter int CANVAS_ROWS = 25,
    parameter int CANVAS_COLS = 60
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // row[7:0], col[15:8], end_col[23:16],
                                        // height[30:24], width[37:31], ink[45:38]
    input  logic [2:0]  s_axis_tuser,   // kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // cell_value[7:0]
    output logic [2:0]  m_axis_tuser    // done_kind[2:0]
);

    localparam int DEPTH = CANVAS_ROWS * CANVAS_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ccsr_status_t status;
    ccsr_cmd_t    push_cmd, pop_cmd;
    logic         q_push, q_pop, q_full, q_empty;
    logic         ram_en, ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]   ram_wdata, ram_rdata;

    // Front end: register the beat, clip the shape, compute row base address
    ccsr_front #(
        .ROWS (CANVAS_ROWS),
        .COLS (CANVAS_COLS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold       (status.init_busy),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_kind    (s_axis_tuser),
        .in_row     (s_axis_tdata[7:0]),
        .in_col     (s_axis_tdata[15:8]),
        .in_end_col (s_axis_tdata[23:16]),
        .in_height  (s_axis_tdata[30:24]),
        .in_width   (s_axis_tdata[37:31]),
        .in_ink     (s_axis_tdata[45:38]),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    // Decouple classification from drawing
    ccsr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    // Draw engine: one canvas cell per cycle, result register at the output
    ccsr_back #(
        .ROWS (CANVAS_ROWS),
        .COLS (CANVAS_COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_cmd     (pop_cmd),
        .ram_en    (ram_en),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_value (m_axis_tdata),
        .status    (status)
    );

    // Canvas store, row-major, no reset: swept to underscore after reset
    ccsr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_canvas (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Only a read result carries a cell value
    `CCSR_ASSERT(a_value_only_on_read, m_axis_tvalid && (m_axis_tuser != KIND_READ) |-> (m_axis_tdata == 8'd0), "cell value set on a non-read result")
    // Clipping keeps every write inside the canvas
    `CCSR_ASSERT(a_write_in_canvas, ram_en && ram_we |-> (32'(ram_addr) < DEPTH), "canvas write beyond last cell")
    // No beat enters while the reset sweep runs
    `CCSR_ASSERT_NEVER(a_no_accept_in_sweep, status.init_busy && s_axis_tvalid && s_axis_tready, "beat accepted during reset sweep")

endmodule
